// ===== hw/rtl/tdmib_pkg.sv =====
`default_nettype none
package tdmib_pkg;

  // window geometry
  localparam int GRID_SIDE  = 256;
  localparam int GRID_HALF  = GRID_SIDE / 2;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int SIDE_AW    = $clog2(GRID_SIDE);
  localparam int CELL_AW    = $clog2(GRID_CELLS);
  localparam int CUR_W      = CELL_AW + 1;

  // fixed field widths
  localparam int POS_W  = 32;
  localparam int OFF_W  = POS_W + 1;
  localparam int INV_W  = 32;
  localparam int PROD_W = OFF_W + INV_W;
  localparam int FRAC_W = 24;
  localparam int IDX_W  = PROD_W - FRAC_W;
  localparam int GRAY_W = 8;
  localparam int Z_W    = 16;
  localparam int CNT_W  = 32;
  localparam int OUTI_W = 8;

  // window bounds on a grid index
  localparam logic signed [IDX_W-1:0] WIN_LO   = IDX_W'(-GRID_HALF);
  localparam logic signed [IDX_W-1:0] WIN_HI   = IDX_W'(GRID_HALF - 1);
  localparam logic signed [IDX_W-1:0] WIN_HALF = IDX_W'(GRID_HALF);
  localparam logic signed [IDX_W-1:0] Z_MAX    = IDX_W'(32767);
  localparam logic signed [IDX_W-1:0] Z_MIN    = IDX_W'(-32768);

  // commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DRAIN  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_VEH_X = 2'd0;
  localparam logic [1:0] REG_VEH_Y = 2'd1;
  localparam logic [1:0] REG_VEH_Z = 2'd2;
  localparam logic [1:0] REG_INV   = 2'd3;

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

  // grid indices of one point
  typedef struct packed {
    logic signed [IDX_W-1:0] x;
    logic signed [IDX_W-1:0] y;
    logic signed [IDX_W-1:0] z;
  } idx_t;

  // one stored cell
  typedef struct packed {
    logic              valid;
    logic [GRAY_W-1:0] intensity;
    logic [Z_W-1:0]    z;
  } cell_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tdmib_scale.sv =====
`default_nettype none
// Scales three offsets by the reciprocal resolution and floors to grid indices.
// One 17x33 multiplier is shared over six partial products, two per axis.
module tdmib_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [tdmib_pkg::OFF_W-1:0]    off_n,
  input  logic signed [tdmib_pkg::OFF_W-1:0]    off_e,
  input  logic signed [tdmib_pkg::OFF_W-1:0]    off_d,
  input  logic [tdmib_pkg::INV_W-1:0]           inv,
  output logic                                  done,
  output tdmib_pkg::idx_t                       idx
);
  import tdmib_pkg::*;

  localparam int HALF_W = 16;
  localparam int MA_W   = OFF_W - HALF_W;
  localparam int MB_W   = INV_W + 1;
  localparam int PP_W   = MA_W + MB_W;

  localparam logic [1:0] AX_N = 2'd0;
  localparam logic [1:0] AX_E = 2'd1;
  localparam logic [2:0] LAST_STEP = 3'd5;

  logic                     busy_r;
  logic                     done_r;
  logic [2:0]               step_r;
  logic                     acc_phase_r;
  logic signed [OFF_W-1:0]  off_n_r, off_e_r, off_d_r;
  logic [INV_W-1:0]         inv_r;
  logic signed [PP_W-1:0]   pp_r;
  logic signed [PROD_W-1:0] acc_r;
  idx_t                     idx_r;

  logic signed [OFF_W-1:0]  off_sel;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PP_W-1:0]   prod;
  logic signed [PROD_W-1:0] pp_ext;
  logic signed [PROD_W-1:0] acc_sum;

  // operand select: low half unsigned, high half signed
  always_comb begin
    case (step_r[2:1])
      AX_N:    off_sel = off_n_r;
      AX_E:    off_sel = off_e_r;
      default: off_sel = off_d_r;
    endcase
    if (step_r[0]) begin
      mul_a = off_sel[OFF_W-1:HALF_W];
    end else begin
      mul_a = signed'({1'b0, off_sel[HALF_W-1:0]});
    end
    mul_b = signed'({1'b0, inv_r});
    prod  = PP_W'(mul_a) * PP_W'(mul_b);
  end

  // accumulate partial product
  always_comb begin
    pp_ext = PROD_W'(pp_r);
    if (step_r[0]) begin
      acc_sum = acc_r + (pp_ext <<< HALF_W);
    end else begin
      acc_sum = pp_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      step_r      <= '0;
      acc_phase_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r      <= 1'b1;
        step_r      <= '0;
        acc_phase_r <= 1'b0;
        off_n_r     <= off_n;
        off_e_r     <= off_e;
        off_d_r     <= off_d;
        inv_r       <= inv;
      end else if (busy_r) begin
        if (!acc_phase_r) begin
          pp_r        <= prod;
          acc_phase_r <= 1'b1;
        end else begin
          acc_phase_r <= 1'b0;
          acc_r       <= acc_sum;
          // floor: arithmetic shift of the exact product
          if (step_r[0]) begin
            case (step_r[2:1])
              AX_N:    idx_r.x <= acc_sum[PROD_W-1:FRAC_W];
              AX_E:    idx_r.y <= acc_sum[PROD_W-1:FRAC_W];
              default: idx_r.z <= acc_sum[PROD_W-1:FRAC_W];
            endcase
          end
          if (step_r == LAST_STEP) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign idx  = idx_r;

endmodule
`default_nettype wire

// ===== hw/rtl/top_down_max_intensity_binning_unit.sv =====
`default_nettype none
// Insert: the shared 17x33 multiplier forms six partial products, two per axis, then one
//   read and one write update the cell; a point outside the window is dropped after the read step.
// Drain: cells are examined one per cycle from the cursor up to the first stored one or the
//   last cell; the strobe comes at the accepting edge itself once the window is exhausted.
// Clear: busy while every cell is written empty. A request is taken only while busy is low.
// Reset: config to defaults, then a clearing pass over every cell with busy high;
//   results show for one cycle on out_valid, the receiver cannot stall.
module top_down_max_intensity_binning_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic signed [tdmib_pkg::POS_W-1:0]  in_pos_north,
  input  logic signed [tdmib_pkg::POS_W-1:0]  in_pos_east,
  input  logic signed [tdmib_pkg::POS_W-1:0]  in_pos_down,
  input  logic [tdmib_pkg::GRAY_W-1:0]        in_intensity,
  output logic                                out_valid,
  output logic                                out_found,
  output logic signed [tdmib_pkg::OUTI_W-1:0] out_cell_north,
  output logic signed [tdmib_pkg::OUTI_W-1:0] out_cell_east,
  output logic signed [tdmib_pkg::Z_W-1:0]    out_cell_down,
  output logic [tdmib_pkg::GRAY_W-1:0]        out_cell_intensity,
  output logic [tdmib_pkg::CNT_W-1:0]         out_dropped_points,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [31:0]                         cfg_wdata
);
  import tdmib_pkg::*;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_INS_SCALE,
    ST_INS_RD,
    ST_INS_WR,
    ST_SCAN
  } state_t;

  state_t                   state_r;
  logic signed [POS_W-1:0]  veh_x_r, veh_y_r, veh_z_r;
  logic [INV_W-1:0]         inv_r;
  logic [CUR_W-1:0]         cursor_r;
  logic [SIDE_AW-1:0]       cur_row_r, cur_col_r;
  logic [CELL_AW-1:0]       clr_addr_r;
  logic [CNT_W-1:0]         dropped_r;
  logic [GRAY_W-1:0]        gray_r;
  logic [CELL_AW-1:0]       addr_r;
  logic                     out_valid_r, out_found_r;
  logic [OUTI_W-1:0]        out_north_r, out_east_r;
  logic [Z_W-1:0]           out_down_r;
  logic [GRAY_W-1:0]        out_gray_r;
  logic [CNT_W-1:0]         out_drop_r;

  cell_t                    mem [GRID_CELLS];
  cell_t                    rd_q;
  logic [CELL_AW-1:0]       rd_addr;
  logic                     mem_we;
  logic [CELL_AW-1:0]       wr_addr;
  cell_t                    wr_data;

  logic                     accept;
  logic                     scale_start, scale_done;
  idx_t                     idx;
  logic signed [OFF_W-1:0]  off_n, off_e, off_d;
  logic                     in_win;
  logic [SIDE_AW-1:0]       ins_row, ins_col;
  logic [CELL_AW-1:0]       ins_addr;
  logic [Z_W-1:0]           z_sat;
  logic                     brighter;
  logic [OUTI_W-1:0]        north_rel, east_rel;
  logic                     scan_last;
  logic [CUR_W-1:0]         cursor_inc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  // offsets from the vehicle, exact in 33 bits
  assign off_n = OFF_W'(in_pos_north) - OFF_W'(veh_x_r);
  assign off_e = OFF_W'(in_pos_east)  - OFF_W'(veh_y_r);
  assign off_d = OFF_W'(in_pos_down)  - OFF_W'(veh_z_r);
  assign scale_start = accept && (in_cmd == CMD_INSERT);

  tdmib_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scale_start),
    .off_n (off_n),
    .off_e (off_e),
    .off_d (off_d),
    .inv   (inv_r),
    .done  (scale_done),
    .idx   (idx)
  );

  // window test and cell address
  assign in_win   = (idx.x >= WIN_LO) && (idx.x <= WIN_HI) &&
                    (idx.y >= WIN_LO) && (idx.y <= WIN_HI);
  assign ins_row  = SIDE_AW'(idx.x + WIN_HALF);
  assign ins_col  = SIDE_AW'(idx.y + WIN_HALF);
  assign ins_addr = CELL_AW'(CELL_AW'(ins_row) * CELL_AW'(GRID_SIDE) + CELL_AW'(ins_col));

  // Z index saturation
  always_comb begin
    if (idx.z > Z_MAX) begin
      z_sat = Z_W'(Z_MAX);
    end else if (idx.z < Z_MIN) begin
      z_sat = Z_W'(Z_MIN);
    end else begin
      z_sat = idx.z[Z_W-1:0];
    end
  end

  assign brighter = !rd_q.valid || (gray_r > rd_q.intensity);

  // drain bookkeeping
  assign cursor_inc = cursor_r + CUR_W'(1);
  assign scan_last  = (cursor_r == CUR_W'(GRID_CELLS - 1));
  assign north_rel  = OUTI_W'(cur_row_r) - OUTI_W'(GRID_HALF);
  assign east_rel   = OUTI_W'(cur_col_r) - OUTI_W'(GRID_HALF);

  // memory port control
  always_comb begin
    case (state_r)
      ST_INS_RD: rd_addr = ins_addr;
      ST_SCAN:   rd_addr = cursor_inc[CELL_AW-1:0];
      default:   rd_addr = cursor_r[CELL_AW-1:0];
    endcase
    mem_we  = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = '0;
    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_INS_WR: begin
        mem_we  = brighter;
        wr_addr = addr_r;
        wr_data = '{valid: 1'b1, intensity: gray_r, z: z_sat};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // cell memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      veh_x_r <= '0;
      veh_y_r <= '0;
      veh_z_r <= '0;
      inv_r   <= INV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VEH_X: veh_x_r <= cfg_wdata;
        REG_VEH_Y: veh_y_r <= cfg_wdata;
        REG_VEH_Z: veh_z_r <= cfg_wdata;
        REG_INV:   inv_r   <= cfg_wdata;
        default:   inv_r   <= inv_r;
      endcase
    end
  end

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      cursor_r    <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + CELL_AW'(1);
          if (clr_addr_r == CELL_AW'(GRID_CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_INSERT: begin
                gray_r  <= in_intensity;
                state_r <= ST_INS_SCALE;
              end
              CMD_DRAIN: begin
                if (cursor_r == CUR_W'(GRID_CELLS)) begin
                  // nothing left: report count only
                  out_valid_r <= 1'b1;
                  out_found_r <= 1'b0;
                  out_north_r <= '0;
                  out_east_r  <= '0;
                  out_down_r  <= '0;
                  out_gray_r  <= '0;
                  out_drop_r  <= dropped_r;
                end else begin
                  state_r <= ST_SCAN;
                end
              end
              CMD_CLEAR: begin
                cursor_r   <= '0;
                cur_row_r  <= '0;
                cur_col_r  <= '0;
                dropped_r  <= '0;
                clr_addr_r <= '0;
                state_r    <= ST_CLR;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_INS_SCALE: begin
          if (scale_done) begin
            state_r <= ST_INS_RD;
          end
        end
        ST_INS_RD: begin
          if (in_win) begin
            addr_r  <= ins_addr;
            state_r <= ST_INS_WR;
          end else begin
            if (dropped_r != '1) begin
              dropped_r <= dropped_r + CNT_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        ST_INS_WR: begin
          state_r <= ST_IDLE;
        end
        ST_SCAN: begin
          // rd_q holds the cell at the cursor
          cursor_r <= cursor_inc;
          if (cur_col_r == SIDE_AW'(GRID_SIDE - 1)) begin
            cur_col_r <= '0;
            cur_row_r <= cur_row_r + SIDE_AW'(1);
          end else begin
            cur_col_r <= cur_col_r + SIDE_AW'(1);
          end
          if (rd_q.valid) begin
            out_valid_r <= 1'b1;
            out_found_r <= 1'b1;
            out_north_r <= north_rel;
            out_east_r  <= east_rel;
            out_down_r  <= rd_q.z;
            out_gray_r  <= rd_q.intensity;
            out_drop_r  <= dropped_r;
            state_r     <= ST_IDLE;
          end else if (scan_last) begin
            out_valid_r <= 1'b1;
            out_found_r <= 1'b0;
            out_north_r <= '0;
            out_east_r  <= '0;
            out_down_r  <= '0;
            out_gray_r  <= '0;
            out_drop_r  <= dropped_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_cell_north     = out_north_r;
  assign out_cell_east      = out_east_r;
  assign out_cell_down      = out_down_r;
  assign out_cell_intensity = out_gray_r;
  assign out_dropped_points = out_drop_r;

  // a result strobe only follows a drain request or a scan step
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past((state_r == ST_SCAN) || (accept && (in_cmd == CMD_DRAIN))))
    else $error("result strobe without a drain");

  // the drain scan never overlaps a memory write
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_we)
    else $error("memory written during drain scan");

  // the cursor never runs past the window
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cursor_r <= CUR_W'(GRID_CELLS)))
    else $error("drain cursor beyond last cell");

  // an insert result lands only after the scaling unit has finished
  a_rd_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_RD) |-> $past(scale_done))
    else $error("cell read before indices ready");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tdmib_pkg::*;

  // the block ignores this command code
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_REQS = 250;
  localparam int PHASES = 6;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] north;
    logic [31:0] east;
    logic [31:0] down;
    logic [7:0]  gray;
  } point_req_t;

  typedef struct {
    logic        found;
    logic [7:0]  north;
    logic [7:0]  east;
    logic [15:0] down;
    logic [7:0]  gray;
    logic [31:0] dropped;
  } bin_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_INSERT;
  logic [31:0] in_pos_north = '0;
  logic [31:0] in_pos_east = '0;
  logic [31:0] in_pos_down = '0;
  logic [7:0]  in_intensity = '0;
  logic        out_valid;
  logic        out_found;
  logic [7:0]  out_cell_north;
  logic [7:0]  out_cell_east;
  logic [15:0] out_cell_down;
  logic [7:0]  out_cell_intensity;
  logic [31:0] out_dropped_points;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_VEH_X;
  logic [31:0] cfg_wdata = '0;

  // predicted state of the binning window
  logic [31:0] veh_north;
  logic [31:0] veh_east;
  logic [31:0] veh_down;
  logic [31:0] inv_res;
  bit          bin_used [GRID_CELLS];
  logic [7:0]  bin_gray [GRID_CELLS];
  logic [15:0] bin_down [GRID_CELLS];
  int          drain_pos;
  logic [31:0] drop_count;

  point_req_t  req_fifo[$];
  bin_report_t expected_bins[$];
  point_req_t  held_req;
  bit          req_taken = 1'b0;
  int          idle_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  int          hot_north = 0;
  int          hot_east = 0;
  logic [7:0]  last_gray = '0;

  always #5 clk = ~clk;

  top_down_max_intensity_binning_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_pos_north       (in_pos_north),
    .in_pos_east        (in_pos_east),
    .in_pos_down        (in_pos_down),
    .in_intensity       (in_intensity),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_cell_north     (out_cell_north),
    .out_cell_east      (out_cell_east),
    .out_cell_down      (out_cell_down),
    .out_cell_intensity (out_cell_intensity),
    .out_dropped_points (out_dropped_points),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // empty every bin, rewind the drain, zero the drop count
  function automatic void clear_bins();
    foreach (bin_used[i]) bin_used[i] = 1'b0;
    drain_pos = 0;
    drop_count = '0;
  endfunction

  function automatic void set_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_VEH_X: veh_north = data;
      REG_VEH_Y: veh_east = data;
      REG_VEH_Z: veh_down = data;
      REG_INV:   inv_res = data;
      default: ;
    endcase
  endfunction

  // floor((pos - base) * inv / 2^24), exact
  function automatic logic signed [41:0] grid_index(logic [31:0] pos, logic [31:0] base);
    logic [32:0]        off;
    logic signed [65:0] prod;
    logic signed [65:0] shifted;
    off = {pos[31], pos} - {base[31], base};
    prod = $signed({{33{off[32]}}, off}) * $signed({34'd0, inv_res});
    shifted = prod >>> 24;
    return shifted[41:0];
  endfunction

  // apply one accepted request to the predicted window
  function automatic void bin_request(point_req_t r);
    logic signed [41:0] gx;
    logic signed [41:0] gy;
    logic signed [41:0] gz;
    int                 addr;
    bin_report_t        rep;
    case (r.cmd)
      CMD_INSERT: begin
        gx = grid_index(r.north, veh_north);
        gy = grid_index(r.east, veh_east);
        gz = grid_index(r.down, veh_down);
        if (gx < -GRID_HALF || gx >= GRID_HALF || gy < -GRID_HALF || gy >= GRID_HALF) begin
          if (drop_count != '1) drop_count = drop_count + 1;
        end else begin
          if (gz > 32767) gz = 32767;
          else if (gz < -32768) gz = -32768;
          addr = (int'(gx) + GRID_HALF) * GRID_SIDE + int'(gy) + GRID_HALF;
          // strictly brighter wins, so the first point keeps a tie
          if (!bin_used[addr] || r.gray > bin_gray[addr]) begin
            bin_used[addr] = 1'b1;
            bin_gray[addr] = r.gray;
            bin_down[addr] = gz[15:0];
          end
        end
      end
      CMD_DRAIN: begin
        rep.found = 1'b0;
        rep.north = '0;
        rep.east = '0;
        rep.down = '0;
        rep.gray = '0;
        while (drain_pos < GRID_CELLS && !rep.found) begin
          if (bin_used[drain_pos]) begin
            rep.found = 1'b1;
            rep.north = 8'(drain_pos / GRID_SIDE - GRID_HALF);
            rep.east = 8'(drain_pos % GRID_SIDE - GRID_HALF);
            rep.down = bin_down[drain_pos];
            rep.gray = bin_gray[drain_pos];
          end
          drain_pos++;
        end
        rep.dropped = drop_count;
        expected_bins.insert(expected_bins.size(), rep);
      end
      CMD_CLEAR: clear_bins();
      default: ;
    endcase
  endfunction

  function automatic point_req_t mk(logic [1:0] c, logic [31:0] n, e, d, logic [7:0] g);
    point_req_t r;
    r.cmd = c;
    r.north = n;
    r.east = e;
    r.down = d;
    r.gray = g;
    return r;
  endfunction

  // append one request to the driver's pending list
  function automatic void queue_req(point_req_t r);
    req_fifo.insert(req_fifo.size(), r);
  endfunction

  // coordinate that lands near grid index k from the given base
  function automatic logic [31:0] aim(int k, logic [31:0] base);
    longint off;
    if (inv_res == 0) return $urandom;
    off = ((longint'(k) <<< 24) + longint'($urandom_range(32'hFF_FFFF))) / longint'(inv_res);
    return 32'(longint'($signed(base)) + off);
  endfunction

  // mostly a small hot spot for collisions, some anywhere, some outside
  function automatic int pick_index(int hot);
    int r;
    r = $urandom_range(99);
    if (r < 55) return hot + int'($urandom_range(4)) - 2;
    if (r < 85) return int'($urandom_range(GRID_SIDE - 1)) - GRID_HALF;
    if (r < 93) return GRID_HALF + int'($urandom_range(40));
    return -GRID_HALF - 1 - int'($urandom_range(40));
  endfunction

  function automatic logic [7:0] pick_gray();
    int r;
    r = $urandom_range(99);
    if (r < 15) return last_gray;
    if (r < 25) last_gray = $urandom_range(1) ? 8'hFF : 8'h00;
    else last_gray = 8'($urandom_range(255));
    return last_gray;
  endfunction

  function automatic point_req_t random_request();
    point_req_t r;
    int         pick;
    pick = $urandom_range(99);
    r.gray = pick_gray();
    r.cmd = (pick < 8) ? CMD_DRAIN : CMD_INSERT;
    if (pick >= 90) begin
      // raw coordinates, now and then an unused command
      r.north = $urandom;
      r.east = $urandom;
      r.down = $urandom;
      if (pick >= 97) r.cmd = CMD_UNUSED;
    end else begin
      r.north = aim(pick_index(hot_north), veh_north);
      r.east = aim(pick_index(hot_east), veh_east);
      r.down = aim(int'($urandom_range(80000)) - 40000, veh_down);
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] x, y, z, inv);
    write_reg(REG_VEH_X, x);
    write_reg(REG_VEH_Y, y);
    write_reg(REG_VEH_Z, z);
    write_reg(REG_INV, inv);
  endtask

  // wait for every request and result, then for a write-back to land
  task automatic settle();
    while (req_fifo.size() != 0 || start || expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // driver: offer the next request and hold it until taken
  always @(negedge clk) begin
    if (!start || req_taken) begin
      if (req_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
        held_req = req_fifo.pop_front();
        in_cmd <= held_req.cmd;
        in_pos_north <= held_req.north;
        in_pos_east <= held_req.east;
        in_pos_down <= held_req.down;
        in_intensity <= held_req.gray;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check drain results, predict each accepted request
  always @(posedge clk) begin
    bin_report_t want;
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        $error("drain result with none expected");
        errors++;
      end else begin
        want = expected_bins.pop_front();
        check_field("found", 32'(want.found), 32'(out_found));
        check_field("cell_north", 32'(want.north), 32'(out_cell_north));
        check_field("cell_east", 32'(want.east), 32'(out_cell_east));
        check_field("cell_down", 32'(want.down), 32'(out_cell_down));
        check_field("cell_intensity", 32'(want.gray), 32'(out_cell_intensity));
        check_field("dropped_points", want.dropped, out_dropped_points);
      end
    end
    req_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) bin_request(held_req);
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    veh_north = '0;
    veh_east = '0;
    veh_down = '0;
    inv_res = INV_RESET;
    clear_bins();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: 256 units per cell
    queue_req(mk(CMD_INSERT, 0, 0, 0, 100));
    queue_req(mk(CMD_INSERT, 255, 255, 2560, 100));         // tie keeps first
    queue_req(mk(CMD_INSERT, 0, 0, 1280, 101));             // brighter replaces
    queue_req(mk(CMD_INSERT, -32768, -32768, 32'h7FFF_FFFF, 255)); // low corner
    queue_req(mk(CMD_INSERT, 32767, 32767, 32'h8000_0000, 0));     // high corner
    queue_req(mk(CMD_INSERT, -32769, 0, 0, 50));            // just outside
    queue_req(mk(CMD_INSERT, 32768, 0, 0, 50));
    queue_req(mk(CMD_INSERT, 0, 32768, 0, 50));
    queue_req(mk(CMD_INSERT, 0, -32769, 0, 50));
    queue_req(mk(CMD_INSERT, '1, '1, '1, 7));               // negative floor
    queue_req(mk(CMD_UNUSED, $urandom, $urandom, $urandom, 8'hA5));
    repeat (3) queue_req(mk(CMD_DRAIN, 0, 0, 0, 0));
    queue_req(mk(CMD_INSERT, -25600, 0, 0, 200));           // behind the cursor
    repeat (2) queue_req(mk(CMD_DRAIN, 0, 0, 0, 0));
    queue_req(mk(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    queue_req(mk(CMD_DRAIN, 0, 0, 0, 0));
    queue_req(mk(CMD_CLEAR, 0, 0, 0, 0));
    settle();

    // largest scale: only a zero offset stays in the window
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    queue_req(mk(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 9));
    queue_req(mk(CMD_INSERT, 32'h7FFF_FFFE, 32'h8000_0000, 0, 9));
    queue_req(mk(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0001, 0, 9));
    settle();

    // zero scale: everything lands in the centre cell
    write_reg(REG_INV, 32'h0);
    queue_req(mk(CMD_INSERT, $urandom, $urandom, $urandom, 9));
    queue_req(mk(CMD_INSERT, $urandom, $urandom, $urandom, 200));
    repeat (2) queue_req(mk(CMD_DRAIN, 0, 0, 0, 0));

    // random phases, each starting from an empty window
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: write_all(32'h0, 32'h0, 32'h0, INV_RESET);
        1: write_all($urandom, $urandom, $urandom, $urandom_range(32'h10_0000, 32'h4000));
        2: write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
        3: write_all($urandom, $urandom, $urandom, 32'h0);
        4: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100_0000);
        default: write_all($urandom, $urandom, $urandom, $urandom);
      endcase
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 64;
        default: idle_pct = 22;
      endcase
      hot_north = int'($urandom_range(GRID_SIDE - 1)) - GRID_HALF;
      hot_east = int'($urandom_range(GRID_SIDE - 1)) - GRID_HALF;
      queue_req(mk(CMD_CLEAR, $urandom, $urandom, $urandom, 8'($urandom)));
      repeat (PHASE_REQS) queue_req(random_request());
      repeat (2) queue_req(mk(CMD_DRAIN, 0, 0, 0, 0));
    end
    settle();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
